// File: design/tce_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the text console character engine.
// No dependencies; tce_datapath, tce_ctrl and the top level refer to it by scoped names.
package tce_pkg;

  // Default screen geometry and tab expansion
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int TAB_SPACES    = 4;

  // Port field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 16;

  // Command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Control characters and glyphs
  localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CHAR_TAB       = 8'd9;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_RETURN    = 8'd13;
  localparam logic [BYTE_W-1:0] GLYPH_SPACE    = 8'h20;

  // Reset contents of every cell and reset attribute
  localparam logic [CELL_W-1:0] CELL_RESET  = 16'h0720;
  localparam logic [BYTE_W-1:0] COLOR_RESET = 8'h07;

  // Cursor operation codes
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE      = 3'd0;
  localparam op_t OP_ADVANCE   = 3'd1;
  localparam op_t OP_NEWLINE   = 3'd2;
  localparam op_t OP_RETURN    = 3'd3;
  localparam op_t OP_BACKSPACE = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic clear_en;
    op_t  op;
    logic glyph_space;
    logic rd_cell;
    logic scroll_start;
    logic scroll_step;
    logic tab_load;
    logic tab_dec;
    logic out_load;
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_read;
    logic in_range;
    logic is_nl;
    logic is_cr;
    logic is_bs;
    logic is_tab;
    logic row_last;
    logic wrap_last;
    logic cnt_last;
    logic tab_last;
    logic tab_more;
  } sts_t;

endpackage

// File: design/tce_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tce_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 2000
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [DATA_W-1:0]          wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [DATA_W-1:0]          rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/tce_datapath.sv
`timescale 1ns / 1ps
// Datapath: item registers, cursor, attribute register, screen RAM, scroll and
// clear address counter, tab counter and result register. Uses tce_pkg, tce_ram.
module tce_datapath #(
  parameter int SCREEN_WIDTH  = tce_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tce_pkg::SCREEN_HEIGHT,
  parameter int TAB_SPACES    = tce_pkg::TAB_SPACES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input word fields
  input  logic                         in_command,
  input  logic [tce_pkg::BYTE_W-1:0]   in_character,
  input  logic [tce_pkg::ROW_W-1:0]    in_read_row,
  input  logic [tce_pkg::COL_W-1:0]    in_read_column,
  // Configuration
  input  logic                         cfg_wr_en,
  input  logic [tce_pkg::BYTE_W-1:0]   cfg_wr_data,
  // Result word fields
  output logic [tce_pkg::ROW_W-1:0]    out_cursor_row,
  output logic [tce_pkg::COL_W-1:0]    out_cursor_column,
  output logic [tce_pkg::POS_W-1:0]    out_cursor_position,
  output logic [tce_pkg::BYTE_W-1:0]   out_cell_glyph,
  output logic [tce_pkg::BYTE_W-1:0]   out_cell_color,
  // Controller link
  input  tce_pkg::ctl_t                ctl,
  output tce_pkg::sts_t                sts
);

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(SCREEN_HEIGHT);
  localparam int CW    = $clog2(SCREEN_WIDTH);
  localparam int TW    = $clog2(TAB_SPACES + 1);
  localparam int OROW_W = tce_pkg::ROW_W;
  localparam int OCOL_W = tce_pkg::COL_W;
  localparam int OPOS_W = tce_pkg::POS_W;

  localparam logic [RW-1:0] ROW_LAST  = RW'(SCREEN_HEIGHT - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(SCREEN_WIDTH - 1);
  localparam logic [AW-1:0] LAST_BASE = AW'(CELLS - SCREEN_WIDTH);
  localparam logic [AW-1:0] CNT_LAST  = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(SCREEN_WIDTH);
  localparam logic [TW-1:0] TAB_LOAD  = TW'(TAB_SPACES);

  // Item registers
  logic                       cmd_r;
  logic [tce_pkg::BYTE_W-1:0] ch_r;
  logic [tce_pkg::ROW_W-1:0]  rrow_r;
  logic [tce_pkg::COL_W-1:0]  rcol_r;

  // Cursor, attribute and counters
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [tce_pkg::BYTE_W-1:0] color_r;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] tab_cnt_r, tab_cnt_nxt;

  // Scroll write pipeline
  logic          sc_wr_r;
  logic [AW-1:0] sc_addr_r;
  logic          sc_blank_r;

  // Result registers
  logic [tce_pkg::ROW_W-1:0]  out_row_r;
  logic [tce_pkg::COL_W-1:0]  out_col_r;
  logic [tce_pkg::POS_W-1:0]  out_pos_r;
  logic [tce_pkg::BYTE_W-1:0] out_glyph_r;
  logic [tce_pkg::BYTE_W-1:0] out_color_r;

  // RAM port signals
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [tce_pkg::CELL_W-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [tce_pkg::CELL_W-1:0] rd_data;

  logic                       row_last;
  logic                       col_last;
  logic                       in_range;
  logic                       src_live;
  logic [AW-1:0]              cell_addr;
  logic [AW-1:0]              src_addr;
  logic [tce_pkg::BYTE_W-1:0] glyph;
  logic                       show_cell;

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= in_command;
      ch_r   <= in_character;
      rrow_r <= in_read_row;
      rcol_r <= in_read_column;
    end
  end

  // Decode status
  assign row_last = (row_r == ROW_LAST);
  assign col_last = (col_r == COL_LAST);
  assign in_range = (32'(rrow_r) < 32'(SCREEN_HEIGHT)) && (32'(rcol_r) < 32'(SCREEN_WIDTH));
  assign cell_addr = AW'(32'(rrow_r) * 32'(SCREEN_WIDTH) + 32'(rcol_r));
  assign src_live = (cnt_r < LAST_BASE);
  assign src_addr = cnt_r + ROW_STEP;
  assign glyph = ctl.glyph_space ? tce_pkg::GLYPH_SPACE : ch_r;

  always_comb begin
    sts.is_read   = (cmd_r == tce_pkg::CMD_READ);
    sts.in_range  = in_range;
    sts.is_nl     = (ch_r == tce_pkg::CHAR_NEWLINE);
    sts.is_cr     = (ch_r == tce_pkg::CHAR_RETURN);
    sts.is_bs     = (ch_r == tce_pkg::CHAR_BACKSPACE);
    sts.is_tab    = (ch_r == tce_pkg::CHAR_TAB);
    sts.row_last  = row_last;
    sts.wrap_last = row_last && col_last;
    sts.cnt_last  = (cnt_r == CNT_LAST);
    sts.tab_last  = (tab_cnt_r == TW'(1));
    sts.tab_more  = (tab_cnt_r != '0);
  end

  // Cursor update; a move off the last row lands on the last row after the scroll
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    pos_nxt = pos_r;
    case (ctl.op)
      tce_pkg::OP_ADVANCE: begin
        if (col_last) begin
          col_nxt = '0;
          if (row_last) begin
            pos_nxt = LAST_BASE;
          end else begin
            row_nxt = row_r + RW'(1);
            pos_nxt = pos_r + AW'(1);
          end
        end else begin
          col_nxt = col_r + CW'(1);
          pos_nxt = pos_r + AW'(1);
        end
      end
      tce_pkg::OP_NEWLINE: begin
        col_nxt = '0;
        if (row_last) begin
          pos_nxt = LAST_BASE;
        end else begin
          row_nxt = row_r + RW'(1);
          pos_nxt = pos_r - AW'(col_r) + ROW_STEP;
        end
      end
      tce_pkg::OP_RETURN: begin
        col_nxt = '0;
        pos_nxt = pos_r - AW'(col_r);
      end
      tce_pkg::OP_BACKSPACE: begin
        if (col_r != '0) begin
          col_nxt = col_r - CW'(1);
          pos_nxt = pos_r - AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Screen write port: clear pass, scroll copy, then cursor writes
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = {color_r, glyph};
    if (ctl.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r;
      wr_data = tce_pkg::CELL_RESET;
    end else if (sc_wr_r) begin
      wr_en   = 1'b1;
      wr_addr = sc_addr_r;
      wr_data = sc_blank_r ? {color_r, tce_pkg::GLYPH_SPACE} : rd_data;
    end else begin
      case (ctl.op)
        tce_pkg::OP_ADVANCE: begin
          wr_en = 1'b1;
        end
        tce_pkg::OP_BACKSPACE: begin
          wr_en   = (col_r != '0);
          wr_addr = pos_r - AW'(1);
          wr_data = {color_r, tce_pkg::GLYPH_SPACE};
        end
        default: begin
        end
      endcase
    end
  end

  // Screen read port: cell read or scroll source one row below
  assign rd_en   = ctl.rd_cell || (ctl.scroll_step && src_live);
  assign rd_addr = ctl.rd_cell ? cell_addr : src_addr;

  // Clear and scroll counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.scroll_start) begin
      cnt_nxt = '0;
    end else if (ctl.clear_en || ctl.scroll_step) begin
      cnt_nxt = (cnt_r == CNT_LAST) ? '0 : cnt_r + AW'(1);
    end
  end

  // Remaining tab spaces
  always_comb begin
    tab_cnt_nxt = tab_cnt_r;
    if (ctl.tab_load) begin
      tab_cnt_nxt = TAB_LOAD;
    end else if (ctl.tab_dec) begin
      tab_cnt_nxt = tab_cnt_r - TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      pos_r     <= '0;
      color_r   <= tce_pkg::COLOR_RESET;
      cnt_r     <= '0;
      tab_cnt_r <= '0;
      sc_wr_r   <= 1'b0;
    end else begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      tab_cnt_r <= tab_cnt_nxt;
      sc_wr_r   <= ctl.scroll_step;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  // Delay the scroll destination to meet the registered read data
  always_ff @(posedge clk) begin
    sc_addr_r  <= cnt_r;
    sc_blank_r <= !src_live;
  end

  // Result register, loaded with the cursor as it stands after this cycle
  assign show_cell = (cmd_r == tce_pkg::CMD_READ) && in_range;

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_row_r   <= OROW_W'(row_nxt);
      out_col_r   <= OCOL_W'(col_nxt);
      out_pos_r   <= OPOS_W'(pos_nxt);
      out_glyph_r <= show_cell ? rd_data[tce_pkg::BYTE_W-1:0] : '0;
      out_color_r <= show_cell ? rd_data[tce_pkg::CELL_W-1:tce_pkg::BYTE_W] : '0;
    end
  end

  assign out_cursor_row      = out_row_r;
  assign out_cursor_column   = out_col_r;
  assign out_cursor_position = out_pos_r;
  assign out_cell_glyph      = out_glyph_r;
  assign out_cell_color      = out_color_r;

  tce_ram #(
    .DATA_W (tce_pkg::CELL_W),
    .DEPTH  (CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: design/tce_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences clear pass, character handling, tab
// expansion, scroll copy and the result handshake. Uses tce_pkg.
module tce_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output tce_pkg::ctl_t ctl,
  input  tce_pkg::sts_t sts
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_TAB    = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       finish;

  assign out_free = !out_valid_r || !out_stall;

  // Next state and datapath commands
  always_comb begin
    ctl       = '0;
    ctl.op    = tce_pkg::OP_NONE;
    state_nxt = state_r;
    finish    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ctl.clear_en = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_read) begin
          ctl.rd_cell = sts.in_range;
          state_nxt   = S_DONE;
        end else if (sts.is_nl) begin
          ctl.op = tce_pkg::OP_NEWLINE;
          if (sts.row_last) begin
            ctl.scroll_start = 1'b1;
            state_nxt        = S_SCROLL;
          end else begin
            finish = 1'b1;
          end
        end else if (sts.is_cr) begin
          ctl.op = tce_pkg::OP_RETURN;
          finish = 1'b1;
        end else if (sts.is_bs) begin
          ctl.op = tce_pkg::OP_BACKSPACE;
          finish = 1'b1;
        end else if (sts.is_tab) begin
          ctl.tab_load = 1'b1;
          state_nxt    = S_TAB;
        end else begin
          ctl.op = tce_pkg::OP_ADVANCE;
          if (sts.wrap_last) begin
            ctl.scroll_start = 1'b1;
            state_nxt        = S_SCROLL;
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_TAB: begin
        ctl.op          = tce_pkg::OP_ADVANCE;
        ctl.glyph_space = 1'b1;
        ctl.tab_dec     = 1'b1;
        if (sts.wrap_last) begin
          ctl.scroll_start = 1'b1;
          state_nxt        = S_SCROLL;
        end else if (sts.tab_last) begin
          finish = 1'b1;
        end
      end
      S_SCROLL: begin
        ctl.scroll_step = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.tab_more) begin
          state_nxt = S_TAB;
        end else begin
          finish = 1'b1;
        end
      end
      S_DONE: begin
        finish = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Hand the result over, or hold it until the output register frees up
    if (finish) begin
      if (out_free) begin
        ctl.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end else begin
        state_nxt = S_DONE;
      end
    end
  end

  // Result word valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !ctl.out_load)
    else $error("result word overwritten while stalled");

  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.capture |=> state_r == S_EXEC)
    else $error("accepted word not executed next cycle");

  a_scroll_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCROLL && sts.cnt_last |=> state_r == S_DRAIN)
    else $error("scroll copy did not end in drain");

  a_tab_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAB |-> sts.tab_more)
    else $error("tab expansion with no spaces left");
`endif

endmodule

// File: design/text_console_character_engine_top.sv
`timescale 1ns / 1ps
// Top level of the text console character engine.
// Uses tce_pkg, tce_ctrl and tce_datapath (which holds the tce_ram screen).
//
// A character-cell console: each input word either prints a byte at the
// cursor (newline, carriage return, backspace and tab handled as controls)
// or reads one screen cell; each word yields exactly one result word with the
// cursor after the word and, for a read, the cell's glyph and attribute.
// After reset the screen RAM is cleared to light-grey blanks, one cell per
// cycle; no input word is accepted until the clear pass ends, and the
// attribute register may be written meanwhile. Each word is captured in
// S_IDLE and executed in S_EXEC; a read then waits in S_DONE for the
// registered cell read, and a tab writes its spaces in S_TAB. A scroll
// copies the screen up one row in S_SCROLL and ends in S_DRAIN: the screen
// RAM has one read and one write port, so rows move up one cell per cycle.
// A result that is not taken holds the engine only once the next word is ready to finish.
module text_console_character_engine_top #(
  parameter int SCREEN_WIDTH  = tce_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tce_pkg::SCREEN_HEIGHT,
  parameter int TAB_SPACES    = tce_pkg::TAB_SPACES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [tce_pkg::BYTE_W-1:0]  in_character,
  input  logic [tce_pkg::ROW_W-1:0]   in_read_row,
  input  logic [tce_pkg::COL_W-1:0]   in_read_column,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tce_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tce_pkg::COL_W-1:0]   out_cursor_column,
  output logic [tce_pkg::POS_W-1:0]   out_cursor_position,
  output logic [tce_pkg::BYTE_W-1:0]  out_cell_glyph,
  output logic [tce_pkg::BYTE_W-1:0]  out_cell_color,
  // Attribute register
  input  logic                        cfg_wr_en,
  input  logic [tce_pkg::BYTE_W-1:0]  cfg_wr_data
);

  tce_pkg::ctl_t ctl;
  tce_pkg::sts_t sts;

  tce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  tce_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TAB_SPACES    (TAB_SPACES)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_command          (in_command),
    .in_character        (in_character),
    .in_read_row         (in_read_row),
    .in_read_column      (in_read_column),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_column   (out_cursor_column),
    .out_cursor_position (out_cursor_position),
    .out_cell_glyph      (out_cell_glyph),
    .out_cell_color      (out_cell_color),
    .ctl                 (ctl),
    .sts                 (sts)
  );

endmodule
